// ===== rtl/lrctm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrctm_pkg
// Shared types and constants for the range clamp and temporal median block.
// ----------------------------------------------------------------------------
package lrctm_pkg;

	localparam int SAMPLE_W    = 16;            // range sample width, mm
	localparam int MAX_WINDOW  = 5;             // scans in the widest median window
	localparam int HIST_N      = MAX_WINDOW - 1; // stored samples per beam
	localparam int CNT_W       = 3;             // history count / window depth width
	localparam int BPS_W       = 11;            // beams_per_scan register width
	localparam int BI_W        = 10;            // beam_index field width
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;            // 16 + 16 + 10 bits, padded to bytes
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_MIN = 2'd0,
		CFG_RANGE_MAX = 2'd1,
		CFG_BEAMS     = 2'd2,
		CFG_WINDOW    = 2'd3
	} cfg_idx_e;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// element 0 is the newest earlier scan
	typedef logic [HIST_N-1:0][SAMPLE_W-1:0] hist_t;

	typedef logic [MAX_WINDOW-1:0][SAMPLE_W-1:0] win_t;

	typedef struct packed {
		sample_t            clamp_lo;
		sample_t            clamp_hi;
		logic [BPS_W-1:0]   beams_per_scan;
		logic [CNT_W-1:0]   window_depth;
	} cfg_regs_t;

	typedef struct packed {
		sample_t            clamped;
		hist_t              hist;
		logic [CNT_W-1:0]   nhist;
		logic [BI_W-1:0]    beam_index;
		logic               last;
	} item_t;

	function automatic sample_t smin(input sample_t a, input sample_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic sample_t smax(input sample_t a, input sample_t b);
		return (a < b) ? b : a;
	endfunction

endpackage

// ===== rtl/lrctm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrctm_front
// Accepts samples, clamps them, tracks beam position and scan count, and
// reads and updates the per-beam history memory.
// ----------------------------------------------------------------------------
module lrctm_front #(
	parameter int MAX_BEAMS = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lrctm_pkg::cfg_regs_t                   cfg,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [lrctm_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output lrctm_pkg::item_t                       push_item
);
	import lrctm_pkg::*;

	localparam int POS_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int LW    = ((POS_W > BPS_W) ? POS_W : BPS_W) + 1;

	// position and scan tracking
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  scans_q;

	// stage 1
	logic              valid_s1;
	sample_t           clamped_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              last_s1;
	logic [CNT_W-1:0]  nhist_s1;
	logic              fwd_s1;
	hist_t             fwd_data_s1;
	hist_t             rdata_s1;

	hist_t             hist_mem [MAX_BEAMS];

	logic              accept;
	logic              advance_s1;
	sample_t           sample_c;
	sample_t           clamped_c;
	logic [BPS_W-1:0]  beams_nz;
	logic [LW-1:0]     pos_next_ext;
	logic              last_c;
	logic [CNT_W-1:0]  depth_m1;
	logic [CNT_W-1:0]  nhist_c;
	hist_t             hist_s1;
	hist_t             wr_data;

	assign advance_s1 = valid_s1 && push_ready;
	assign s_tready   = !valid_s1 || push_ready;
	assign accept     = s_tvalid && s_tready;

	assign sample_c = s_tdata[SAMPLE_W-1:0];

	always_comb begin
		priority if (sample_c < cfg.clamp_lo) begin
			clamped_c = cfg.clamp_lo;
		end else if (sample_c > cfg.clamp_hi) begin
			clamped_c = cfg.clamp_hi;
		end else begin
			clamped_c = sample_c;
		end
	end

	// a scan length of zero acts as one; past MAX_BEAMS the position bound wins
	assign beams_nz     = (cfg.beams_per_scan == '0) ? BPS_W'(1) : cfg.beams_per_scan;
	assign pos_next_ext = LW'(pos_q) + LW'(1);
	assign last_c       = (pos_next_ext >= LW'(beams_nz)) || (pos_next_ext >= LW'(MAX_BEAMS));

	always_comb begin
		priority if (cfg.window_depth == '0) begin
			depth_m1 = '0;
		end else if (cfg.window_depth > CNT_W'(MAX_WINDOW)) begin
			depth_m1 = CNT_W'(MAX_WINDOW - 1);
		end else begin
			depth_m1 = cfg.window_depth - CNT_W'(1);
		end
	end

	assign nhist_c = (scans_q < depth_m1) ? scans_q : depth_m1;

	// take the write of the same cycle as the read when both hit one beam
	assign hist_s1 = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign wr_data = hist_t'({hist_s1[HIST_N-2:0], clamped_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			scans_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (last_c) begin
					pos_q <= '0;
					if (scans_q < CNT_W'(HIST_N)) begin
						scans_q <= scans_q + CNT_W'(1);
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			hist_mem[pos_s1] <= wr_data;
		end
		if (accept) begin
			rdata_s1    <= hist_mem[pos_q];
			fwd_s1      <= advance_s1 && (pos_s1 == pos_q);
			fwd_data_s1 <= wr_data;
			clamped_s1  <= clamped_c;
			pos_s1      <= pos_q;
			last_s1     <= last_c;
			nhist_s1    <= nhist_c;
		end
	end

	assign push_valid           = valid_s1;
	assign push_item.clamped    = clamped_s1;
	assign push_item.hist       = hist_s1;
	assign push_item.nhist      = nhist_s1;
	assign push_item.beam_index = BI_W'(pos_s1);
	assign push_item.last       = last_s1;

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_c |=> pos_q == '0)
		else $error("beam position not cleared after last beam");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_c |=> pos_q == POS_W'($past(pos_q) + POS_W'(1)))
		else $error("beam position did not advance by one");

	a_scans_sat: assert property (@(posedge clk) disable iff (!arst_n)
		scans_q <= CNT_W'(HIST_N))
		else $error("scan count beyond history depth");

endmodule

// ===== rtl/lrctm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrctm_queue
// Short FIFO between the history front end and the median back end.
// ----------------------------------------------------------------------------
module lrctm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  lrctm_pkg::item_t  push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output lrctm_pkg::item_t  pop_item
);
	import lrctm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_QW'(1);
				2'b01:   count_q <= count_q - CNT_QW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/lrctm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrctm_back
// Five-input sorting network over two stages, then median select and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module lrctm_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    pop_valid,
	output logic                                    pop_ready,
	input  lrctm_pkg::item_t                        pop_item,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [lrctm_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                    m_tlast
);
	import lrctm_pkg::*;

	logic               advance;

	win_t               pad_c;
	win_t               l1_c, l2_c, l3_c, l4_c, l5_c;

	logic               valid_s1, valid_s2;
	win_t               sort_s1, sort_s2;
	logic               even_s1, even_s2;
	sample_t            clamped_s1, clamped_s2;
	logic [BI_W-1:0]    bi_s1, bi_s2;
	logic               last_s1, last_s2;

	logic [SAMPLE_W:0]  mid_sum;
	sample_t            median_c;

	sample_t            clamped_q;
	sample_t            median_q;
	logic [BI_W-1:0]    bi_q;
	logic               last_q;

	assign advance   = !m_tvalid || m_tready;
	assign pop_ready = advance;

	// pad unused slots alternately low and high so the middle stays in place
	always_comb begin
		pad_c[0] = pop_item.clamped;
		for (int j = 1; j < MAX_WINDOW; j++) begin
			if (CNT_W'(j) <= pop_item.nhist) begin
				pad_c[j] = pop_item.hist[j-1];
			end else if (((CNT_W'(j) - pop_item.nhist) & CNT_W'(1)) != '0) begin
				pad_c[j] = '0;
			end else begin
				pad_c[j] = '1;
			end
		end
	end

	always_comb begin
		l1_c    = pad_c;
		l1_c[0] = smin(pad_c[0], pad_c[3]);
		l1_c[3] = smax(pad_c[0], pad_c[3]);
		l1_c[1] = smin(pad_c[1], pad_c[4]);
		l1_c[4] = smax(pad_c[1], pad_c[4]);

		l2_c    = l1_c;
		l2_c[0] = smin(l1_c[0], l1_c[2]);
		l2_c[2] = smax(l1_c[0], l1_c[2]);
		l2_c[1] = smin(l1_c[1], l1_c[3]);
		l2_c[3] = smax(l1_c[1], l1_c[3]);

		l3_c    = l2_c;
		l3_c[0] = smin(l2_c[0], l2_c[1]);
		l3_c[1] = smax(l2_c[0], l2_c[1]);
		l3_c[2] = smin(l2_c[2], l2_c[4]);
		l3_c[4] = smax(l2_c[2], l2_c[4]);
	end

	always_comb begin
		l4_c    = sort_s1;
		l4_c[1] = smin(sort_s1[1], sort_s1[2]);
		l4_c[2] = smax(sort_s1[1], sort_s1[2]);
		l4_c[3] = smin(sort_s1[3], sort_s1[4]);
		l4_c[4] = smax(sort_s1[3], sort_s1[4]);

		l5_c    = l4_c;
		l5_c[2] = smin(l4_c[2], l4_c[3]);
		l5_c[3] = smax(l4_c[2], l4_c[3]);
	end

	// even count: floor of the mean of the two middle values
	assign mid_sum  = {1'b0, sort_s2[2]} + {1'b0, sort_s2[3]};
	assign median_c = even_s2 ? mid_sum[SAMPLE_W:1] : sort_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			m_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sort_s1    <= l3_c;
			even_s1    <= pop_item.nhist[0];
			clamped_s1 <= pop_item.clamped;
			bi_s1      <= pop_item.beam_index;
			last_s1    <= pop_item.last;

			sort_s2    <= l5_c;
			even_s2    <= even_s1;
			clamped_s2 <= clamped_s1;
			bi_s2      <= bi_s1;
			last_s2    <= last_s1;

			clamped_q  <= clamped_s2;
			median_q   <= median_c;
			bi_q       <= bi_s2;
			last_q     <= last_s2;
		end
	end

	assign m_tdata = {{(OUT_TDATA_W - 2*SAMPLE_W - BI_W){1'b0}}, bi_q, median_q, clamped_q};
	assign m_tlast = last_q;

endmodule

// ===== rtl/lidar_range_clamp_temporal_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_clamp_temporal_median
// Per-beam range clamp and temporal median over up to five scans.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one range sample per transaction, beams in scan order.
//   Output stream m_*: one result per sample, in order; tdata carries the
//   clamped sample, the median and the beam index, tlast marks the last beam
//   of a scan.
//   Config channel cfg_*: always ready; write only while the block is idle.
//   Throughput: one sample per cycle while m_tready is high. A result passes
//   the history read stage, the queue and two sorting stages, then leaves the
//   output register.
//   When m_tready is low the back end holds; the two-entry queue and the
//   front stage fill, then s_tready drops.
//   Reset clears beam position, scan count and pipeline valids and loads the
//   register defaults. History memory is not cleared; the user, not the block,
//   ensures a beam's history is only read after earlier scans have written it.
// ----------------------------------------------------------------------------
module lidar_range_clamp_temporal_median #(
	parameter int MAX_BEAMS = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [lrctm_pkg::IN_TDATA_W-1:0]       s_tdata,   // [15:0] sample_mm
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [lrctm_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [15:0] clamped_mm,
	                                                          // [31:16] median_mm,
	                                                          // [41:32] beam_index
	output logic                                   m_tlast,   // scan_end
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lrctm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lrctm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lrctm_pkg::*;

	cfg_regs_t  cfg_q;
	logic       push_valid;
	logic       push_ready;
	item_t      push_item;
	logic       pop_valid;
	logic       pop_ready;
	item_t      pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clamp_lo       <= SAMPLE_W'(30);
			cfg_q.clamp_hi       <= SAMPLE_W'(50000);
			cfg_q.beams_per_scan <= BPS_W'(1000);
			cfg_q.window_depth   <= CNT_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_RANGE_MIN: cfg_q.clamp_lo       <= cfg_data[SAMPLE_W-1:0];
				CFG_RANGE_MAX: cfg_q.clamp_hi       <= cfg_data[SAMPLE_W-1:0];
				CFG_BEAMS:     cfg_q.beams_per_scan <= cfg_data[BPS_W-1:0];
				CFG_WINDOW:    cfg_q.window_depth   <= cfg_data[CNT_W-1:0];
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	lrctm_front #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	lrctm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lrctm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range clamp and per-beam temporal median block.
// A short table of directed transactions covers the clamp extremes, crossed
// limits, out-of-range scan length and window settings and a scan cut short;
// random phases then stream noisy scans under changing settings. Every result
// is checked field by field against a table entry or an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;

	import lrctm_pkg::*;

	localparam int NBEAMS = 1024;

	typedef struct packed {
		logic [SAMPLE_W-1:0] clamped;
		logic [SAMPLE_W-1:0] median;
		logic [BI_W-1:0]     beam;
		logic                scan_end;
	} range_out_t;

	typedef struct {
		bit            is_reg;
		cfg_idx_e      reg_idx;
		logic [15:0]   value;
		bit            typed;
		range_out_t    want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_RANGE_MIN;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// predictor copy of the registers and per-beam state
	logic [SAMPLE_W-1:0] lim_lo     = 16'd30;
	logic [SAMPLE_W-1:0] lim_hi     = 16'd50000;
	logic [BPS_W-1:0]    beams_reg  = 11'd1000;
	logic [CNT_W-1:0]    depth_reg  = 3'd5;
	hist_t               beam_hist [NBEAMS];
	int                  fill_cnt [NBEAMS];
	int                  next_beam  = 0;
	int                  scans_done = 0;

	range_out_t          median_q [$];
	dir_row_t            dir_rows [$];
	logic [SAMPLE_W-1:0] scene_mm [NBEAMS];
	int                  src_gap_max = 0;
	int                  snk_gap_max = 0;
	int                  n_bad       = 0;
	bit                  src_busy    = 1'b0;
	bit                  cfg_busy    = 1'b0;

	lidar_range_clamp_temporal_median #(
		.MAX_BEAMS(NBEAMS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("FAIL lidar_range_clamp_temporal_median");
		$finish;
	end

	function automatic int eff_beams(input logic [BPS_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > NBEAMS)
			return NBEAMS;
		return int'(v);
	endfunction

	function automatic int eff_depth(input logic [CNT_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(v);
	endfunction

	// clamp, take the median over this beam's window and advance the beam state
	function automatic range_out_t predict_clamp_median(input logic [SAMPLE_W-1:0] raw);
		range_out_t          r;
		logic [SAMPLE_W-1:0] w [MAX_WINDOW];
		logic [SAMPLE_W-1:0] c, t;
		logic [SAMPLE_W:0]   pair;
		int                  beams, used, n, p, i, j;
		beams = eff_beams(beams_reg);
		p = next_beam;
		c = (raw < lim_lo) ? lim_lo : (raw > lim_hi) ? lim_hi : raw;
		used = eff_depth(depth_reg) - 1;
		if (scans_done < used)
			used = scans_done;
		w[0] = c;
		n = 1;
		for (i = 0; i < used; i++) begin
			w[n] = beam_hist[p][i];
			n++;
		end
		for (i = 1; i < n; i++) begin
			t = w[i];
			j = i;
			while (j > 0 && w[j-1] > t) begin
				w[j] = w[j-1];
				j--;
			end
			w[j] = t;
		end
		if (n % 2 == 1) begin
			r.median = w[n/2];
		end else begin
			pair = {1'b0, w[n/2-1]} + {1'b0, w[n/2]};
			r.median = pair[SAMPLE_W:1];
		end
		for (i = HIST_N - 1; i > 0; i--)
			beam_hist[p][i] = beam_hist[p][i-1];
		beam_hist[p][0] = c;
		if (fill_cnt[p] < HIST_N)
			fill_cnt[p]++;
		r.clamped  = c;
		r.beam     = p[BI_W-1:0];
		r.scan_end = (p + 1 >= beams);
		if (r.scan_end) begin
			next_beam = 0;
			if (scans_done < HIST_N)
				scans_done++;
		end else begin
			next_beam = p + 1;
		end
		return r;
	endfunction

	// dry run of positions: would any sample read history never written?
	function automatic bit history_covered(input int beams, input int depth, input int n);
		int cnt [NBEAMS];
		int pos, scans, used, k;
		cnt = fill_cnt;
		pos = next_beam;
		scans = scans_done;
		for (k = 0; k < n; k++) begin
			used = (scans < depth - 1) ? scans : depth - 1;
			if (used > cnt[pos])
				return 1'b0;
			if (cnt[pos] < HIST_N)
				cnt[pos]++;
			if (pos + 1 >= beams) begin
				pos = 0;
				if (scans < HIST_N)
					scans++;
			end else begin
				pos++;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_range_sample();
		int p, k, v;
		p = next_beam;
		k = $urandom_range(0, 19);
		if (k < 10) begin
			v = int'(scene_mm[p]) + int'($urandom_range(0, 100)) - 50;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
		end else if (k < 13) begin
			v = $urandom_range(0, 65535);
		end else if (k == 13) begin
			v = 0;
		end else if (k == 14) begin
			v = 65535;
		end else if (k < 17) begin
			v = int'(lim_lo) + int'($urandom_range(0, 4)) - 2;
		end else if (k < 19) begin
			v = int'(lim_hi) + int'($urandom_range(0, 4)) - 2;
		end else begin
			// move the target seen by this beam
			scene_mm[p] = SAMPLE_W'($urandom_range(200, 60000));
			v = scene_mm[p];
		end
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic void add_reg(input cfg_idx_e idx, input logic [15:0] v);
		dir_row_t row;
		row.is_reg  = 1'b1;
		row.reg_idx = idx;
		row.value   = v;
		row.typed   = 1'b0;
		row.want    = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_smp(input logic [15:0] v, input bit typed,
			input logic [15:0] c, input logic [15:0] m, input int b, input bit e);
		dir_row_t row;
		row.is_reg         = 1'b0;
		row.reg_idx        = CFG_RANGE_MIN;
		row.value          = v;
		row.typed          = typed;
		row.want.clamped   = c;
		row.want.median    = m;
		row.want.beam      = b[BI_W-1:0];
		row.want.scan_end  = e;
		dir_rows.push_back(row);
	endfunction

	task automatic write_reg(input cfg_idx_e idx, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		cfg_busy = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RANGE_MIN: lim_lo    = v;
			CFG_RANGE_MAX: lim_hi    = v;
			CFG_BEAMS:     beams_reg = v[BPS_W-1:0];
			CFG_WINDOW:    depth_reg = v[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [15:0] v, input bit typed, input range_out_t want);
		range_out_t r;
		int         gap;
		if (cfg_busy) begin
			cfg_valid <= 1'b0;
			cfg_busy = 1'b0;
		end
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		src_busy = 1'b1;
		do @(posedge clk); while (!s_tready);
		r = predict_clamp_median(v);
		median_q.push_back(typed ? want : r);
	endtask

	// drop the sample stream and hold until every result is back
	task automatic settle();
		if (src_busy) begin
			s_tvalid <= 1'b0;
			src_busy = 1'b0;
		end
		while (median_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : sink
		int w;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			w = $urandom_range(0, snk_gap_max);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	always @(posedge clk) begin
		range_out_t got, want;
		if (m_tvalid && m_tready) begin
			got.clamped  = m_tdata[15:0];
			got.median   = m_tdata[31:16];
			got.beam     = m_tdata[41:32];
			got.scan_end = m_tlast;
			if (median_q.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected result: clamped %0d median %0d beam %0d end %0b",
						got.clamped, got.median, got.beam, got.scan_end);
				n_bad++;
			end else begin
				want = median_q.pop_front();
				if (got.clamped !== want.clamped || got.median !== want.median ||
						got.beam !== want.beam || got.scan_end !== want.scan_end) begin
					if (n_bad < 10)
						$display("mismatch: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b %s",
							want.clamped, want.median, want.beam, want.scan_end,
							got.clamped, got.median, got.beam, got.scan_end,
							"(clamped/median/beam/end)");
					n_bad++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [15:0] new_lo, new_hi, junk;
		logic [BPS_W-1:0] new_bps;
		logic [CNT_W-1:0] new_win;
		range_out_t blank;
		int n_items, n, b, k, lo, hi, i;
		blank = '0;
		n_items = 0;
		for (i = 0; i < NBEAMS; i++)
			scene_mm[i] = SAMPLE_W'($urandom_range(200, 60000));

		// reset limits 30..50000, scan of 1000 beams, window of five
		add_smp(16'd0,     1'b1, 16'd30,    16'd30,    0, 1'b0);
		add_smp(16'd65535, 1'b1, 16'd50000, 16'd50000, 1, 1'b0);
		add_smp(16'd30,    1'b1, 16'd30,    16'd30,    2, 1'b0);
		add_smp(16'd50000, 1'b1, 16'd50000, 16'd50000, 3, 1'b0);
		add_smp(16'd29,    1'b1, 16'd30,    16'd30,    4, 1'b0);
		add_smp(16'd50001, 1'b1, 16'd50000, 16'd50000, 5, 1'b0);
		add_smp(16'd1234,  1'b1, 16'd1234,  16'd1234,  6, 1'b0);
		// zero scan length acts as one beam: cut the running scan short
		add_reg(CFG_BEAMS, 16'd0);
		add_smp(16'd100,   1'b1, 16'd100,   16'd100,   7, 1'b1);
		add_smp(16'd200,   1'b0, 16'd0,     16'd0,     0, 1'b0);
		// crossed limits
		add_reg(CFG_RANGE_MIN, 16'd40000);
		add_reg(CFG_RANGE_MAX, 16'd1000);
		add_smp(16'd500,   1'b0, 16'd0,     16'd0,     0, 1'b0);
		add_smp(16'd45000, 1'b0, 16'd0,     16'd0,     0, 1'b0);
		// zero window acts as one scan
		add_reg(CFG_WINDOW, 16'd0);
		add_smp(16'd0,     1'b1, 16'd40000, 16'd40000, 0, 1'b1);
		// full range, oversized window acts as five
		add_reg(CFG_RANGE_MIN, 16'd0);
		add_reg(CFG_RANGE_MAX, 16'd65535);
		add_reg(CFG_WINDOW, 16'd7);
		add_smp(16'd65535, 1'b0, 16'd0,     16'd0,     0, 1'b0);
		add_smp(16'd0,     1'b0, 16'd0,     16'd0,     0, 1'b0);
		add_smp(16'd65535, 1'b0, 16'd0,     16'd0,     0, 1'b0);
		// oversized scan length acts as the full beam count; upper data bits masked
		add_reg(CFG_WINDOW, 16'd1);
		add_reg(CFG_BEAMS, 16'hFFFF);
		add_smp(16'd65535, 1'b1, 16'd65535, 16'd65535, 0, 1'b0);
		add_smp(16'd12345, 1'b1, 16'd12345, 16'd12345, 1, 1'b0);
		add_reg(CFG_RANGE_MAX, 16'd0);
		add_smp(16'd65535, 1'b1, 16'd0,     16'd0,     2, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_max = 8;
		snk_gap_max = 8;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				settle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		while (n_items < 1800) begin
			new_lo  = lim_lo;
			new_hi  = lim_hi;
			new_bps = beams_reg;
			if ($urandom_range(0, 1) == 1) begin
				k = $urandom_range(0, 9);
				if (k == 0) begin
					lo = 0;
					hi = 65535;
				end else if (k == 1) begin
					lo = $urandom_range(1, 65535);
					hi = $urandom_range(0, lo - 1);
				end else if (k == 2) begin
					lo = $urandom_range(0, 65535);
					hi = lo;
				end else if (k < 6) begin
					lo = $urandom_range(0, 200);
					hi = $urandom_range(20000, 65535);
				end else begin
					lo = $urandom_range(0, 40000);
					hi = lo + int'($urandom_range(0, 25535));
					if (hi > 65535)
						hi = 65535;
				end
				new_lo = lo[15:0];
				new_hi = hi[15:0];
			end
			if ($urandom_range(0, 2) != 0) begin
				k = $urandom_range(0, 19);
				if (k == 0 && n_items < 1000)
					new_bps = ($urandom_range(0, 1) == 1) ? 11'd1024
						: BPS_W'($urandom_range(1025, 2047));
				else if (k < 3)
					new_bps = '0;
				else if (k < 5)
					new_bps = BPS_W'($urandom_range(13, 64));
				else
					new_bps = BPS_W'($urandom_range(1, 12));
			end
			new_win = CNT_W'($urandom_range(0, 7));
			b = eff_beams(new_bps);
			if (b > 64)
				n = b + $urandom_range(0, 16);
			else if (b > 12)
				n = b * $urandom_range(1, 3) + $urandom_range(0, b - 1);
			else
				n = b * $urandom_range(1, 8) + $urandom_range(0, b - 1);
			// narrow the window while a longer scan has beams not yet filled
			if (!history_covered(b, eff_depth(new_win), n))
				new_win = CNT_W'($urandom_range(0, 1));

			settle();
			if (new_lo != lim_lo || $urandom_range(0, 3) == 0)
				write_reg(CFG_RANGE_MIN, new_lo);
			if (new_hi != lim_hi || $urandom_range(0, 3) == 0)
				write_reg(CFG_RANGE_MAX, new_hi);
			junk = 16'($urandom);
			if (new_bps != beams_reg || $urandom_range(0, 3) == 0)
				write_reg(CFG_BEAMS, {junk[15:BPS_W], new_bps});
			junk = 16'($urandom);
			if (new_win != depth_reg || $urandom_range(0, 3) == 0)
				write_reg(CFG_WINDOW, {junk[15:CNT_W], new_win});

			k = $urandom_range(0, 2);
			src_gap_max = (k == 0) ? 0 : (k == 1) ? 2 : 8;
			k = $urandom_range(0, 2);
			snk_gap_max = (k == 0) ? 0 : (k == 1) ? 2 : 8;
			repeat (n)
				send_sample(pick_range_sample(), 1'b0, blank);
			n_items += n;
		end

		settle();
		repeat (12) @(posedge clk);
		if (n_bad == 0)
			$display("PASS lidar_range_clamp_temporal_median");
		else
			$display("FAIL lidar_range_clamp_temporal_median");
		$finish;
	end

endmodule
